// ===== rtl/hcb_pkg.sv =====
package hcb_pkg;

    localparam int PIX_W      = 8;
    localparam int READ_W     = 9;
    localparam int BINS_CFG_W = 5;
    localparam int THR_W      = 9;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 9;
    localparam int OUT_CNT_W  = 32;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_READ   = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NUM_HUE_BINS  = 3'd0,
        CFG_NUM_SAT_BINS  = 3'd1,
        CFG_NUM_VAL_BINS  = 3'd2,
        CFG_SAT_THRESHOLD = 3'd3,
        CFG_VAL_THRESHOLD = 3'd4
    } t_cfg_idx;

    localparam logic [BINS_CFG_W-1:0] RST_NUM_HUE_BINS  = 5'd10;
    localparam logic [BINS_CFG_W-1:0] RST_NUM_SAT_BINS  = 5'd10;
    localparam logic [BINS_CFG_W-1:0] RST_NUM_VAL_BINS  = 5'd10;
    localparam logic [THR_W-1:0]      RST_SAT_THRESHOLD = 9'd26;
    localparam logic [THR_W-1:0]      RST_VAL_THRESHOLD = 9'd51;

endpackage

// ===== rtl/hsv_color_histogram_binner.sv =====
// Channel  Direction  Handshake                Payload
// in       input      i_in_valid / o_in_stall  op, hue, saturation, brightness, read_bin
// out      output     o_out_valid / i_out_stall bin_used, bin_count, pixel_total, out_of_range
// cfg      input      i_cfg_we                 i_cfg_idx, i_cfg_data
// One word is worked at a time: the next word is taken only after the result of the last
// one is registered. A word passes through two index stages, one read of the count memory
// and one write-back.
// After reset a clearing pass zeroes all MAX_HUE_BINS*MAX_SAT_BINS+MAX_VAL_BINS entries of
// the count memory, one entry per cycle; no input word is taken meanwhile.
// A stalled result holds the write-back until the output register is free.
module hsv_color_histogram_binner
    import hcb_pkg::*;
#(
    parameter int MAX_HUE_BINS = 16,
    parameter int MAX_SAT_BINS = 16,
    parameter int MAX_VAL_BINS = 16,
    parameter int COUNT_WIDTH  = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic                  i_op,
    input  logic [PIX_W-1:0]      i_hue,
    input  logic [PIX_W-1:0]      i_saturation,
    input  logic [PIX_W-1:0]      i_brightness,
    input  logic [READ_W-1:0]     i_read_bin,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [READ_W-1:0]     o_bin_used,
    output logic [OUT_CNT_W-1:0]  o_bin_count,
    output logic [OUT_CNT_W-1:0]  o_pixel_total,
    output logic                  o_out_of_range,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int DEPTH  = MAX_HUE_BINS * MAX_SAT_BINS + MAX_VAL_BINS;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int BIN_W  = (ADDR_W > READ_W) ? ADDR_W : READ_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_QUANT,
        S_BIN,
        S_READ,
        S_UPDATE
    } t_state;

    t_state                 r_state;
    logic [BINS_CFG_W-1:0]  r_num_hue_bins;
    logic [BINS_CFG_W-1:0]  r_num_sat_bins;
    logic [BINS_CFG_W-1:0]  r_num_val_bins;
    logic [THR_W-1:0]       r_sat_threshold;
    logic [THR_W-1:0]       r_val_threshold;
    logic                   r_op;
    logic [PIX_W-1:0]       r_hue;
    logic [PIX_W-1:0]       r_saturation;
    logic [PIX_W-1:0]       r_brightness;
    logic [READ_W-1:0]      r_read_bin;
    logic [COUNT_WIDTH-1:0] r_total;
    logic                   r_out_valid;
    logic [READ_W-1:0]      r_out_bin;
    logic [OUT_CNT_W-1:0]   r_out_count;
    logic [OUT_CNT_W-1:0]   r_out_total;
    logic                   r_out_oor;

    logic [BIN_W-1:0]       bin;
    logic                   bin_oor;
    logic [COUNT_WIDTH-1:0] rd_data;
    logic                   clearing;
    logic                   in_take;
    logic                   out_free;
    logic                   upd_go;
    logic                   mem_wr_en;
    logic [COUNT_WIDTH-1:0] n_count;
    logic [COUNT_WIDTH-1:0] n_total;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_hue_bins  <= RST_NUM_HUE_BINS;
            r_num_sat_bins  <= RST_NUM_SAT_BINS;
            r_num_val_bins  <= RST_NUM_VAL_BINS;
            r_sat_threshold <= RST_SAT_THRESHOLD;
            r_val_threshold <= RST_VAL_THRESHOLD;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_NUM_HUE_BINS:  r_num_hue_bins  <= i_cfg_data[BINS_CFG_W-1:0];
                CFG_NUM_SAT_BINS:  r_num_sat_bins  <= i_cfg_data[BINS_CFG_W-1:0];
                CFG_NUM_VAL_BINS:  r_num_val_bins  <= i_cfg_data[BINS_CFG_W-1:0];
                CFG_SAT_THRESHOLD: r_sat_threshold <= i_cfg_data[THR_W-1:0];
                CFG_VAL_THRESHOLD: r_val_threshold <= i_cfg_data[THR_W-1:0];
                default: begin
                end
            endcase
        end
    end

    hcb_bin_calc #(
        .MAX_HUE_BINS (MAX_HUE_BINS),
        .MAX_SAT_BINS (MAX_SAT_BINS),
        .MAX_VAL_BINS (MAX_VAL_BINS),
        .BIN_W        (BIN_W)
    ) u_bin_calc (
        .i_clk           (i_clk),
        .i_op            (r_op),
        .i_hue           (r_hue),
        .i_saturation    (r_saturation),
        .i_brightness    (r_brightness),
        .i_read_bin      (r_read_bin),
        .i_num_hue_bins  (r_num_hue_bins),
        .i_num_sat_bins  (r_num_sat_bins),
        .i_num_val_bins  (r_num_val_bins),
        .i_sat_threshold (r_sat_threshold),
        .i_val_threshold (r_val_threshold),
        .o_bin           (bin),
        .o_out_of_range  (bin_oor)
    );

    hcb_count_store #(
        .DEPTH       (DEPTH),
        .ADDR_W      (ADDR_W),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_count_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_en    (r_state == S_READ),
        .i_wr_en    (mem_wr_en),
        .i_addr     (bin[ADDR_W-1:0]),
        .i_wr_data  (n_count),
        .o_rd_data  (rd_data),
        .o_clearing (clearing)
    );

    assign o_in_stall = clearing || (r_state != S_IDLE);
    assign in_take    = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;
    assign upd_go     = (r_state == S_UPDATE) && out_free;
    assign mem_wr_en  = upd_go && (r_op == OP_INSERT);

    assign n_count = (rd_data == '1) ? rd_data : rd_data + COUNT_WIDTH'(1);
    assign n_total = (r_total == '1) ? r_total : r_total + COUNT_WIDTH'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_total     <= '0;
        end else begin
            if (r_out_valid && !i_out_stall && !upd_go) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_take) begin
                        r_op         <= i_op;
                        r_hue        <= i_hue;
                        r_saturation <= i_saturation;
                        r_brightness <= i_brightness;
                        r_read_bin   <= i_read_bin;
                        r_state      <= S_QUANT;
                    end
                end
                S_QUANT: r_state <= S_BIN;
                S_BIN:   r_state <= S_READ;
                S_READ:  r_state <= S_UPDATE;
                S_UPDATE: begin
                    if (upd_go) begin
                        r_out_valid <= 1'b1;
                        r_out_bin   <= bin[READ_W-1:0];
                        r_out_oor   <= bin_oor;
                        if (r_op == OP_INSERT) begin
                            r_total     <= n_total;
                            r_out_total <= OUT_CNT_W'(n_total);
                            r_out_count <= OUT_CNT_W'(n_count);
                        end else begin
                            r_out_total <= OUT_CNT_W'(r_total);
                            r_out_count <= bin_oor ? '0 : OUT_CNT_W'(rd_data);
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_bin_used     = r_out_bin;
    assign o_bin_count    = r_out_count;
    assign o_pixel_total  = r_out_total;
    assign o_out_of_range = r_out_oor;

endmodule

// ===== rtl/hcb_bin_calc.sv =====
module hcb_bin_calc
    import hcb_pkg::*;
#(
    parameter int MAX_HUE_BINS = 16,
    parameter int MAX_SAT_BINS = 16,
    parameter int MAX_VAL_BINS = 16,
    parameter int BIN_W        = 9
) (
    input  logic                  i_clk,
    input  logic                  i_op,
    input  logic [PIX_W-1:0]      i_hue,
    input  logic [PIX_W-1:0]      i_saturation,
    input  logic [PIX_W-1:0]      i_brightness,
    input  logic [READ_W-1:0]     i_read_bin,
    input  logic [BINS_CFG_W-1:0] i_num_hue_bins,
    input  logic [BINS_CFG_W-1:0] i_num_sat_bins,
    input  logic [BINS_CFG_W-1:0] i_num_val_bins,
    input  logic [THR_W-1:0]      i_sat_threshold,
    input  logic [THR_W-1:0]      i_val_threshold,
    output logic [BIN_W-1:0]      o_bin,
    output logic                  o_out_of_range
);

    localparam int QP_W  = PIX_W + BINS_CFG_W + 1;
    localparam int CMP_W = BIN_W + 1;

    function automatic logic [BINS_CFG_W-1:0] eff_bins(
        input logic [BINS_CFG_W-1:0] r,
        input int unsigned           max_bins
    );
        logic [BINS_CFG_W-1:0] e;
        if (r == '0) begin
            e = BINS_CFG_W'(1);
        end else if (32'(r) > max_bins) begin
            e = BINS_CFG_W'(max_bins);
        end else begin
            e = r;
        end
        return e;
    endfunction

    // Floor of x*n/255 is (p + (p >> 8) + 1) >> 8 for the product range used here.
    function automatic logic [BINS_CFG_W-1:0] quant(
        input logic [PIX_W-1:0]      x,
        input logic [BINS_CFG_W-1:0] n
    );
        logic [QP_W-1:0]       p;
        logic [QP_W-1:0]       q;
        logic [BINS_CFG_W-1:0] r;
        p = QP_W'(x) * QP_W'(n);
        q = (p + (p >> PIX_W) + QP_W'(1)) >> PIX_W;
        if (q >= QP_W'(n)) begin
            r = n - BINS_CFG_W'(1);
        end else begin
            r = q[BINS_CFG_W-1:0];
        end
        return r;
    endfunction

    logic [BINS_CFG_W-1:0] nh;
    logic [BINS_CFG_W-1:0] ns;
    logic [BINS_CFG_W-1:0] nv;

    logic [BIN_W-1:0]      r_hs_bins;
    logic [BINS_CFG_W-1:0] r_hq;
    logic [BINS_CFG_W-1:0] r_sq;
    logic [BINS_CFG_W-1:0] r_vq;
    logic                  r_colorless;
    logic                  r_op;
    logic [READ_W-1:0]     r_read_bin;
    logic [BIN_W-1:0]      n_bin;
    logic [CMP_W-1:0]      used;

    assign nh = eff_bins(i_num_hue_bins, MAX_HUE_BINS);
    assign ns = eff_bins(i_num_sat_bins, MAX_SAT_BINS);
    assign nv = eff_bins(i_num_val_bins, MAX_VAL_BINS);

    always_ff @(posedge i_clk) begin
        r_hs_bins   <= BIN_W'(nh) * BIN_W'(ns);
        r_hq        <= quant(i_hue, nh);
        r_sq        <= quant(i_saturation, ns);
        r_vq        <= quant(i_brightness, nv);
        r_colorless <= ({1'b0, i_saturation} < i_sat_threshold) ||
                       ({1'b0, i_brightness} < i_val_threshold);
        r_op        <= i_op;
        r_read_bin  <= i_read_bin;
    end

    assign used = CMP_W'(r_hs_bins) + CMP_W'(nv);

    always_comb begin
        if (r_op == OP_READ) begin
            n_bin = BIN_W'(r_read_bin);
        end else if (r_colorless) begin
            n_bin = r_hs_bins + BIN_W'(r_vq);
        end else begin
            n_bin = BIN_W'(r_sq) * BIN_W'(nh) + BIN_W'(r_hq);
        end
    end

    always_ff @(posedge i_clk) begin
        o_bin          <= n_bin;
        o_out_of_range <= (r_op == OP_READ) && (CMP_W'(r_read_bin) >= used);
    end

endmodule

// ===== rtl/hcb_count_store.sv =====
module hcb_count_store #(
    parameter int DEPTH       = 272,
    parameter int ADDR_W      = 9,
    parameter int COUNT_WIDTH = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_rd_en,
    input  logic                   i_wr_en,
    input  logic [ADDR_W-1:0]      i_addr,
    input  logic [COUNT_WIDTH-1:0] i_wr_data,
    output logic [COUNT_WIDTH-1:0] o_rd_data,
    output logic                   o_clearing
);

    logic [COUNT_WIDTH-1:0] mem [DEPTH];
    logic [ADDR_W-1:0]      r_clr_addr;
    logic                   r_clearing;
    logic                   wr_en;
    logic [ADDR_W-1:0]      wr_addr;
    logic [COUNT_WIDTH-1:0] wr_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            if (r_clr_addr == ADDR_W'(DEPTH - 1)) begin
                r_clearing <= 1'b0;
            end
            r_clr_addr <= r_clr_addr + ADDR_W'(1);
        end
    end

    assign wr_en   = r_clearing || i_wr_en;
    assign wr_addr = r_clearing ? r_clr_addr : i_addr;
    assign wr_data = r_clearing ? '0 : i_wr_data;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= mem[i_addr];
        end
    end

    assign o_clearing = r_clearing;

endmodule

// ===== bench/tb_hsv_color_histogram_binner.sv =====
`timescale 1ns / 1ps

module tb_hsv_color_histogram_binner;
    import hcb_pkg::*;

    localparam int MAX_HUE        = 16;
    localparam int MAX_SAT        = 16;
    localparam int MAX_VAL        = 16;
    localparam int STORE_DEPTH    = MAX_HUE * MAX_SAT + MAX_VAL;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES   = 20;
    localparam int WORDS_PER_MODE = 520;

    typedef struct packed {
        logic [READ_W-1:0]    bin;
        logic [OUT_CNT_W-1:0] count;
        logic [OUT_CNT_W-1:0] total;
        logic                 oor;
    } t_bin_report;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_stall;
    logic                  i_op;
    logic [PIX_W-1:0]      i_hue;
    logic [PIX_W-1:0]      i_saturation;
    logic [PIX_W-1:0]      i_brightness;
    logic [READ_W-1:0]     i_read_bin;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    logic [READ_W-1:0]     o_bin_used;
    logic [OUT_CNT_W-1:0]  o_bin_count;
    logic [OUT_CNT_W-1:0]  o_pixel_total;
    logic                  o_out_of_range;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    logic [BINS_CFG_W-1:0] hue_bins_reg;
    logic [BINS_CFG_W-1:0] sat_bins_reg;
    logic [BINS_CFG_W-1:0] val_bins_reg;
    logic [THR_W-1:0]      sat_thr_reg;
    logic [THR_W-1:0]      val_thr_reg;
    logic [OUT_CNT_W-1:0]  bin_tally [STORE_DEPTH];
    logic [OUT_CNT_W-1:0]  pixel_tally;
    t_bin_report           expected_reports [$];

    int sender_idle_pct = 29;
    int recv_stall_pct  = 71;
    int mismatch_count  = 0;
    int quiet_cycles    = 0;

    hsv_color_histogram_binner #(
        .MAX_HUE_BINS (MAX_HUE),
        .MAX_SAT_BINS (MAX_SAT),
        .MAX_VAL_BINS (MAX_VAL),
        .COUNT_WIDTH  (OUT_CNT_W)
    ) DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_op           (i_op),
        .i_hue          (i_hue),
        .i_saturation   (i_saturation),
        .i_brightness   (i_brightness),
        .i_read_bin     (i_read_bin),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_bin_used     (o_bin_used),
        .o_bin_count    (o_bin_count),
        .o_pixel_total  (o_pixel_total),
        .o_out_of_range (o_out_of_range),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int unsigned bins_in_use(logic [BINS_CFG_W-1:0] setting,
                                                int unsigned max_n);
        if (setting == '0) begin
            return 1;
        end
        if (32'(setting) > max_n) begin
            return max_n;
        end
        return 32'(setting);
    endfunction

    function automatic int unsigned level_of(logic [PIX_W-1:0] x, int unsigned n);
        int unsigned q;
        q = (32'(x) * n) / 255;
        return (q > n - 1) ? n - 1 : q;
    endfunction

    function automatic int unsigned layout_size();
        return bins_in_use(hue_bins_reg, MAX_HUE) * bins_in_use(sat_bins_reg, MAX_SAT)
               + bins_in_use(val_bins_reg, MAX_VAL);
    endfunction

    function automatic void tally_word(logic op, logic [PIX_W-1:0] h, logic [PIX_W-1:0] s,
                                       logic [PIX_W-1:0] v, logic [READ_W-1:0] rb);
        int unsigned nh;
        int unsigned ns;
        int unsigned nv;
        int unsigned bin;
        t_bin_report r;
        nh = bins_in_use(hue_bins_reg, MAX_HUE);
        ns = bins_in_use(sat_bins_reg, MAX_SAT);
        nv = bins_in_use(val_bins_reg, MAX_VAL);
        r  = '0;
        if (op == OP_INSERT) begin
            if (s < sat_thr_reg || v < val_thr_reg) begin
                bin = nh * ns + level_of(v, nv);
            end else begin
                bin = level_of(s, ns) * nh + level_of(h, nh);
            end
            if (bin_tally[bin] != '1) begin
                bin_tally[bin] = bin_tally[bin] + 1'b1;
            end
            r.count = bin_tally[bin];
            if (pixel_tally != '1) begin
                pixel_tally = pixel_tally + 1'b1;
            end
        end else begin
            bin = 32'(rb);
            if (bin < nh * ns + nv) begin
                r.count = bin_tally[bin];
            end else begin
                r.oor = 1'b1;
            end
        end
        r.bin   = bin[READ_W-1:0];
        r.total = pixel_tally;
        expected_reports.push_back(r);
    endfunction

    function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_NUM_HUE_BINS:  hue_bins_reg = data[BINS_CFG_W-1:0];
            CFG_NUM_SAT_BINS:  sat_bins_reg = data[BINS_CFG_W-1:0];
            CFG_NUM_VAL_BINS:  val_bins_reg = data[BINS_CFG_W-1:0];
            CFG_SAT_THRESHOLD: sat_thr_reg  = data[THR_W-1:0];
            CFG_VAL_THRESHOLD: val_thr_reg  = data[THR_W-1:0];
            default: ;
        endcase
    endfunction

    function automatic void check_field(string name, logic [OUT_CNT_W-1:0] want,
                                        logic [OUT_CNT_W-1:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    task automatic send_word(logic op, logic [PIX_W-1:0] h, logic [PIX_W-1:0] s,
                             logic [PIX_W-1:0] v, logic [READ_W-1:0] rb);
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            @(negedge i_clk);
            i_in_valid = 1'b0;
        end
        @(negedge i_clk);
        i_in_valid   = 1'b1;
        i_op         = op;
        i_hue        = h;
        i_saturation = s;
        i_brightness = v;
        i_read_bin   = rb;
        do begin
            @(posedge i_clk);
        end while (o_in_stall);
        tally_word(op, h, s, v, rb);
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (expected_reports.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = data;
        apply_reg(idx, data);
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic set_layout(logic [CFG_DATA_W-1:0] nh, logic [CFG_DATA_W-1:0] ns,
                              logic [CFG_DATA_W-1:0] nv, logic [CFG_DATA_W-1:0] st,
                              logic [CFG_DATA_W-1:0] vt);
        wait_idle();
        write_reg(CFG_NUM_HUE_BINS, nh);
        write_reg(CFG_NUM_SAT_BINS, ns);
        write_reg(CFG_NUM_VAL_BINS, nv);
        write_reg(CFG_SAT_THRESHOLD, st);
        write_reg(CFG_VAL_THRESHOLD, vt);
    endtask

    function automatic logic [CFG_DATA_W-1:0] random_bins_setting();
        logic [CFG_DATA_W-1:0] d;
        case ($urandom_range(0, 9))
            0:       d = '0;
            1:       d = CFG_DATA_W'($urandom_range(17, 31));
            default: d = CFG_DATA_W'($urandom_range(1, 16));
        endcase
        if ($urandom_range(0, 3) == 0) begin
            d[CFG_DATA_W-1:BINS_CFG_W] = (CFG_DATA_W-BINS_CFG_W)'($urandom_range(0, 15));
        end
        return d;
    endfunction

    function automatic logic [CFG_DATA_W-1:0] random_threshold();
        case ($urandom_range(0, 9))
            0:       return CFG_DATA_W'($urandom_range(256, 511));
            1:       return '0;
            2:       return CFG_DATA_W'($urandom_range(0, 255));
            default: return CFG_DATA_W'($urandom_range(0, 80));
        endcase
    endfunction

    task automatic test_default_layout();
        send_word(OP_INSERT, 8'd0, 8'd255, 8'd255, '0);
        send_word(OP_INSERT, 8'd255, 8'd255, 8'd255, '1);
        send_word(OP_INSERT, 8'd128, 8'd26, 8'd51, '0);
        send_word(OP_INSERT, 8'd200, 8'd25, 8'd255, '0);
        send_word(OP_INSERT, 8'd200, 8'd255, 8'd50, '0);
        send_word(OP_INSERT, 8'd0, 8'd0, 8'd0, '0);
        send_word(OP_INSERT, 8'hAA, 8'h55, 8'hAA, 9'h155);
        send_word(OP_INSERT, 8'h55, 8'hAA, 8'h55, 9'h0AA);
        send_word(OP_READ, 8'd0, 8'd0, 8'd0, 9'd90);
        send_word(OP_READ, 8'hFF, 8'hFF, 8'hFF, 9'd109);
        send_word(OP_READ, 8'd0, 8'd0, 8'd0, 9'd110);
        send_word(OP_READ, 8'd0, 8'd0, 8'd0, 9'd511);
        send_word(OP_READ, 8'd0, 8'd0, 8'd0, 9'd0);
    endtask

    task automatic test_layout_extremes();
        set_layout(9'd0, 9'd0, 9'd0, 9'd26, 9'd51);
        send_word(OP_INSERT, 8'd255, 8'd255, 8'd255, '0);
        send_word(OP_INSERT, 8'd0, 8'd255, 8'd0, '0);
        send_word(OP_READ, 8'd0, 8'd0, 8'd0, 9'd1);
        send_word(OP_READ, 8'd0, 8'd0, 8'd0, 9'd2);
        set_layout(9'h1F0, 9'd17, 9'd31, 9'd26, 9'd51);
        send_word(OP_INSERT, 8'd255, 8'd255, 8'd255, '0);
        send_word(OP_INSERT, 8'd255, 8'd0, 8'd255, '0);
        send_word(OP_READ, 8'd0, 8'd0, 8'd0, 9'd271);
        send_word(OP_READ, 8'd0, 8'd0, 8'd0, 9'd272);
    endtask

    task automatic test_threshold_extremes();
        set_layout(9'd10, 9'd10, 9'd10, 9'd0, 9'd0);
        send_word(OP_INSERT, 8'd0, 8'd0, 8'd0, '0);
        set_layout(9'd10, 9'd10, 9'd10, 9'd256, 9'd511);
        send_word(OP_INSERT, 8'd255, 8'd255, 8'd255, '0);
        wait_idle();
        // Writes to unassigned register indexes must leave the layout untouched.
        for (int k = int'(CFG_VAL_THRESHOLD) + 1; k < (1 << CFG_IDX_W); k++) begin
            write_reg(k[CFG_IDX_W-1:0], '1);
        end
        send_word(OP_INSERT, 8'd255, 8'd255, 8'd255, '0);
        send_word(OP_READ, 8'd0, 8'd0, 8'd0, 9'd109);
    endtask

    task automatic test_random_traffic(int n_words);
        int remaining;
        int burst;
        int unsigned used;
        remaining = n_words;
        while (remaining > 0) begin
            set_layout(random_bins_setting(), random_bins_setting(), random_bins_setting(),
                       random_threshold(), random_threshold());
            burst = $urandom_range(30, 120);
            if (burst > remaining) begin
                burst = remaining;
            end
            for (int i = 0; i < burst; i++) begin
                if ($urandom_range(0, 99) < 30) begin
                    used = layout_size();
                    send_word(OP_READ, PIX_W'($urandom_range(0, 255)),
                              PIX_W'($urandom_range(0, 255)),
                              PIX_W'($urandom_range(0, 255)),
                              READ_W'(($urandom_range(0, 3) != 0)
                                      ? $urandom_range(0, used + 2)
                                      : $urandom_range(0, 511)));
                end else begin
                    send_word(OP_INSERT, PIX_W'($urandom_range(0, 255)),
                              PIX_W'($urandom_range(0, 255)),
                              PIX_W'($urandom_range(0, 255)),
                              READ_W'($urandom_range(0, 511)));
                end
            end
            remaining -= burst;
        end
    endtask

    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end

    always @(posedge i_clk) begin
        t_bin_report want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_reports.size() == 0) begin
                $display("%0t: word with none expected, actual bin %0d count %0d total %0d",
                         $time, o_bin_used, o_bin_count, o_pixel_total);
                mismatch_count++;
            end else begin
                want = expected_reports.pop_front();
                check_field("bin_used", OUT_CNT_W'(want.bin), OUT_CNT_W'(o_bin_used));
                check_field("bin_count", want.count, o_bin_count);
                check_field("pixel_total", want.total, o_pixel_total);
                check_field("out_of_range", OUT_CNT_W'(want.oor), OUT_CNT_W'(o_out_of_range));
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || i_cfg_we) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired with %0d words outstanding", $time,
                     expected_reports.size());
            $display("end of test: mismatches");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_op         = OP_INSERT;
        i_hue        = '0;
        i_saturation = '0;
        i_brightness = '0;
        i_read_bin   = '0;
        i_cfg_we     = 1'b0;
        i_cfg_idx    = CFG_NUM_HUE_BINS;
        i_cfg_data   = '0;
        hue_bins_reg = RST_NUM_HUE_BINS;
        sat_bins_reg = RST_NUM_SAT_BINS;
        val_bins_reg = RST_NUM_VAL_BINS;
        sat_thr_reg  = RST_SAT_THRESHOLD;
        val_thr_reg  = RST_VAL_THRESHOLD;
        pixel_tally  = '0;
        foreach (bin_tally[k]) begin
            bin_tally[k] = '0;
        end
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_default_layout();
        test_layout_extremes();
        test_threshold_extremes();
        test_random_traffic(WORDS_PER_MODE);
        sender_idle_pct = 71;
        recv_stall_pct  = 29;
        test_random_traffic(WORDS_PER_MODE);
        sender_idle_pct = 0;
        recv_stall_pct  = 0;
        test_random_traffic(WORDS_PER_MODE);

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

// ===== hsv_color_histogram_binner.f =====
rtl/hcb_pkg.sv
rtl/hcb_bin_calc.sv
rtl/hcb_count_store.sv
rtl/hsv_color_histogram_binner.sv
bench/tb_hsv_color_histogram_binner.sv
